[src/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register indexes and helpers for the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DIV_W = 52;
    localparam int DEN_W = 20;
    localparam int ACC_W = 66;
    localparam logic [DEN_W-1:0] US_PER_SECOND = 20'd1000000;
    localparam logic [31:0]      US_RECIP      = 32'd2251799813;
    localparam logic [21:0]      US_ONE        = 22'd1000000;
    localparam logic [21:0]      US_TWO        = 22'd2000000;

    localparam logic [2:0] REG_OUT_MIN  = 3'd0;
    localparam logic [2:0] REG_OUT_MAX  = 3'd1;
    localparam logic [2:0] REG_GAIN_FF  = 3'd2;
    localparam logic [2:0] REG_GAIN_P   = 3'd3;
    localparam logic [2:0] REG_GAIN_I   = 3'd4;
    localparam logic [2:0] REG_GAIN_D   = 3'd5;
    localparam logic [2:0] REG_INT_LIM  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_IMUL, ST_IREC, ST_IQM, ST_IUPD,
        ST_DMUL, ST_DDIVS, ST_DDIV, ST_DUPD,
        ST_MAC0, ST_MAC1, ST_MAC2, ST_MAC3, ST_MACE, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_INT, OP_DER, OP_FF, OP_P, OP_I, OP_D, OP_REC, OP_QM
    } op_sel_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
        if (v > 54'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -54'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[src/pid_controller_with_antiwindup.sv]
// ----------------------------------------------------------------------------
// pid_controller_with_antiwindup
// PID step with feed-forward term, integral clamp and output clamp, Q16.16.
// ----------------------------------------------------------------------------
// One item is one control step: the error, then the integral update when the
// integral is enabled, then the derivative through the bit-serial divider when
// the derivative is enabled, then the multiply-accumulate of the feed-forward,
// P, I and D terms and the clamped output; a stalled result keeps the block in
// the final state. The integral
// step divides by one second with a reciprocal multiply and a remainder
// correction. A single 33x33 multiplier is shared by all terms; s_ready is
// high only between steps, and a finished drive value waits in the output
// register while the next item is taken.
module pid_controller_with_antiwindup (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_setpoint,
    input  logic signed [31:0] s_measured,
    input  logic [19:0]        s_elapsed_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_drive
);
    import pidc_pkg::*;

    logic signed [31:0] out_min_reg, out_max_reg, kc_reg, kp_reg, ki_reg, kd_reg;
    logic [30:0]        lim_reg;

    logic signed [31:0] sp_reg, meas_reg, err_reg, last_reg, integ_reg, rate_reg;
    logic [19:0]        us_reg;
    logic               first_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic signed [31:0] drive_reg;
    logic               mvalid_reg;
    logic [50:0]        pmag_reg;
    logic               pneg_reg, qneg_reg;
    logic [31:0]        q0_reg;

    state_t  state_reg, state_next;
    op_sel_t op_sel;
    div_ctl_t div_ctl;
    logic    acc_clear, acc_add, out_load;

    logic signed [32:0] mul_a, mul_b, diff;
    logic signed [ACC_W-1:0] mul_p;
    logic [ACC_W-1:0]   mag;
    logic [DIV_W-1:0]   quo;
    logic signed [52:0] squo;
    logic [21:0]        irem;
    logic [1:0]         icorr;
    logic [31:0]        iquo;
    logic signed [32:0] iinc;
    logic signed [53:0] isum, ilim;
    logic signed [49:0] sh, d1, d2;
    logic               do_int, do_der, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_min_reg <= -32'sd65536;
            out_max_reg <= 32'sd65536;
            kc_reg      <= '0;
            kp_reg      <= 32'sd65536;
            ki_reg      <= '0;
            kd_reg      <= '0;
            lim_reg     <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_OUT_MIN: out_min_reg <= pwdata;
                REG_OUT_MAX: out_max_reg <= pwdata;
                REG_GAIN_FF: kc_reg      <= pwdata;
                REG_GAIN_P:  kp_reg      <= pwdata;
                REG_GAIN_I:  ki_reg      <= pwdata;
                REG_GAIN_D:  kd_reg      <= pwdata;
                REG_INT_LIM: lim_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OUT_MIN: prdata = out_min_reg;
            REG_OUT_MAX: prdata = out_max_reg;
            REG_GAIN_FF: prdata = kc_reg;
            REG_GAIN_P:  prdata = kp_reg;
            REG_GAIN_I:  prdata = ki_reg;
            REG_GAIN_D:  prdata = kd_reg;
            REG_INT_LIM: prdata = {1'b0, lim_reg};
            default:     prdata = '0;
        endcase
    end

    assign do_int = !first_reg && (ki_reg != 0);
    assign do_der = !first_reg && (kd_reg != 0) && (us_reg != 0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_ERR;
            ST_ERR:   state_next = do_int ? ST_IMUL : (do_der ? ST_DMUL : ST_MAC0);
            ST_IMUL:  state_next = ST_IREC;
            ST_IREC:  state_next = ST_IQM;
            ST_IQM:   state_next = ST_IUPD;
            ST_IUPD:  state_next = do_der ? ST_DMUL : ST_MAC0;
            ST_DMUL:  state_next = ST_DDIVS;
            ST_DDIVS: state_next = ST_DDIV;
            ST_DDIV:  if (div_ctl.done) state_next = ST_DUPD;
            ST_DUPD:  state_next = ST_MAC0;
            ST_MAC0:  state_next = ST_MAC1;
            ST_MAC1:  state_next = ST_MAC2;
            ST_MAC2:  state_next = ST_MAC3;
            ST_MAC3:  state_next = ST_MACE;
            ST_MACE:  state_next = ST_OUT;
            ST_OUT:   if (!mvalid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_sel        = OP_INT;
        div_ctl.start = 1'b0;
        acc_clear     = 1'b0;
        acc_add       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IREC:  op_sel = OP_REC;
            ST_IQM:   op_sel = OP_QM;
            ST_DMUL:  op_sel = OP_DER;
            ST_DDIVS: div_ctl.start = 1'b1;
            ST_MAC0:  op_sel = OP_FF;
            ST_MAC1: begin
                op_sel    = OP_P;
                acc_clear = 1'b1;
            end
            ST_MAC2: begin
                op_sel  = OP_I;
                acc_add = 1'b1;
            end
            ST_MAC3: begin
                op_sel  = OP_D;
                acc_add = 1'b1;
            end
            ST_MACE:  acc_add = 1'b1;
            ST_OUT:   out_load = !mvalid_reg || m_ready;
            default: ;
        endcase
    end

    assign diff = {err_reg[31], err_reg} - {last_reg[31], last_reg};

    assign mag = prod_reg[ACC_W-1] ? ACC_W'(-prod_reg) : prod_reg;

    always_comb begin
        case (op_sel)
            OP_INT: begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {13'b0, us_reg};
            end
            OP_DER: begin
                mul_a = diff;
                mul_b = {13'b0, US_PER_SECOND};
            end
            OP_FF: begin
                mul_a = {kc_reg[31], kc_reg};
                mul_b = {sp_reg[31], sp_reg};
            end
            OP_P: begin
                mul_a = {kp_reg[31], kp_reg};
                mul_b = {err_reg[31], err_reg};
            end
            OP_I: begin
                mul_a = {ki_reg[31], ki_reg};
                mul_b = {integ_reg[31], integ_reg};
            end
            OP_D: begin
                mul_a = {kd_reg[31], kd_reg};
                mul_b = {rate_reg[31], rate_reg};
            end
            OP_REC: begin
                mul_a = {1'b0, mag[50:19]};
                mul_b = {1'b0, US_RECIP};
            end
            OP_QM: begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = {13'b0, US_PER_SECOND};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .dividend (mag[DIV_W-1:0]),
        .divisor  (us_reg),
        .done     (div_ctl.done),
        .quotient (quo)
    );

    always_comb begin
        squo  = qneg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        irem  = 22'(pmag_reg - prod_reg[50:0]);
        icorr = (irem >= US_TWO) ? 2'd2 : ((irem >= US_ONE) ? 2'd1 : 2'd0);
        iquo  = q0_reg + {30'b0, icorr};
        iinc  = pneg_reg ? -$signed({1'b0, iquo}) : $signed({1'b0, iquo});
        isum  = {{22{integ_reg[31]}}, integ_reg} + {{21{iinc[32]}}, iinc};
        ilim  = {23'b0, lim_reg};
        if (lim_reg != 0 && (isum > ilim || isum < -ilim)) begin
            isum = (isum > 0) ? ilim : -ilim;
        end
        sh = acc_reg[ACC_W-1:16];
        d1 = (sh < 50'(out_min_reg)) ? 50'(out_min_reg) : sh;
        d2 = (d1 > 50'(out_max_reg)) ? 50'(out_max_reg) : d1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            first_reg  <= 1'b1;
            last_reg   <= '0;
            integ_reg  <= '0;
            rate_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IUPD) integ_reg <= sat32(isum);
            if (state_reg == ST_DUPD) rate_reg <= sat32({squo[52], squo});
            if (state_reg == ST_MACE) begin
                last_reg  <= err_reg;
                first_reg <= 1'b0;
            end
            if (out_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            sp_reg   <= s_setpoint;
            meas_reg <= s_measured;
            us_reg   <= s_elapsed_us;
        end
        if (state_reg == ST_ERR) begin
            err_reg <= sat32(54'(meas_reg) - 54'(sp_reg));
        end
        if (state_reg == ST_IREC) begin
            pmag_reg <= mag[50:0];
            pneg_reg <= prod_reg[ACC_W-1];
        end
        if (state_reg == ST_IQM) q0_reg <= prod_reg[63:32];
        if (div_ctl.start) qneg_reg <= prod_reg[ACC_W-1];
        prod_reg <= mul_p;
        if (acc_clear) begin
            acc_reg <= prod_reg;
        end else if (acc_add) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (out_load) drive_reg <= d2[31:0];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;
    assign m_drive = drive_reg;

endmodule

[src/pidc_div.sv]
// ----------------------------------------------------------------------------
// pidc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pidc_pkg::DIV_W-1:0]  dividend,
    input  logic [pidc_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [pidc_pkg::DIV_W-1:0]  quotient
);
    import pidc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = !busy_reg && !start;
    assign quotient = quo_reg;

endmodule

[src/pidc_checker.sv]
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_drive
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a step is in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result item dropped before it was taken");

    a_drive_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_drive))
        else $error("result item changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

endmodule

bind pid_controller_with_antiwindup pidc_checker u_pidc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_drive (m_drive)
);
